// ===== rtl/tclt_pkg.sv =====
// Shared types, codes and defaults for the texture cache LRU table.
`default_nettype none
package tclt_pkg;

	// Default table depth
	localparam int unsigned ENTRIES_DEF = 256;

	// Action codes
	localparam logic [2:0] ACT_LOOKUP   = 3'd0;
	localparam logic [2:0] ACT_NORMAL   = 3'd1;
	localparam logic [2:0] ACT_EV_OLD   = 3'd2;
	localparam logic [2:0] ACT_EV_STALE = 3'd3;
	localparam logic [2:0] ACT_INVAL    = 3'd4;

	// Status codes
	localparam logic [2:0] ST_HIT     = 3'd0;
	localparam logic [2:0] ST_MISS    = 3'd1;
	localparam logic [2:0] ST_NOSPACE = 3'd2;
	localparam logic [2:0] ST_NOIMAGE = 3'd3;
	localparam logic [2:0] ST_MAINT   = 3'd4;

	localparam logic [8:0] CNT_MAX = 9'h1FF;

	typedef struct packed {
		logic [2:0]  action;
		logic [31:0] image_id;
		logic [31:0] image_version;
		logic [31:0] current_frame;
		logic [8:0]  evict_tries;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] slot;
		logic       load_needed;
		logic       build_normal;
		logic [8:0] evicted_count;
	} rsp_t;

	// One table slot as stored in memory
	typedef struct packed {
		logic [31:0] tag;
		logic [31:0] last_use;
		logic [31:0] version;
		logic        is_normal;
	} entry_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_REC_RD,
		S_REC_CHK,
		S_SCAN,
		S_STALE,
		S_ALLOC,
		S_INVAL,
		S_OLD,
		S_OLD_CLR,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/texture_cache_lru_table.sv =====
// Top level: fully associative texture slot table with LRU-style eviction.
//
//   channel | signals            | beat taken when
//   --------+--------------------+-------------------------------
//   request | start, req, busy   | start high while busy is low
//   result  | done, rsp          | done high (one cycle, no stall)
//
// One slot is read per cycle from the slot memory. A lookup first checks the
// recent slot, else scans the table for a hit or an empty slot; if none is
// found it runs a stale pass and then allocates the first slot it freed.
// Evict oldest runs a scan and a clear per evicted entry and a last scan when
// it runs out of candidates; evict stale and invalidate each scan the table. After
// reset the memory is cleared one slot a cycle with busy high.
// The result is shown for one cycle only; the receiver cannot hold it off.
`default_nettype none
module texture_cache_lru_table import tclt_pkg::*; #(
	parameter int unsigned ENTRIES = ENTRIES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire req_t req,
	output logic      busy,
	output logic      done,
	output rsp_t      rsp
);

	localparam int unsigned AW = $clog2(ENTRIES);

	logic [AW-1:0] rd_addr, wr_addr;
	logic          wr_en;
	entry_t        rd_data, wr_data;

	tclt_ctrl #(.ENTRIES(ENTRIES), .AW(AW)) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (req),
		.busy    (busy),
		.done    (done),
		.rsp     (rsp),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	tclt_mem #(.ENTRIES(ENTRIES), .AW(AW)) u_mem (
		.clk     (clk),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

endmodule
`default_nettype wire

// ===== rtl/tclt_mem.sv =====
// Slot memory: one write port, one registered read port.
`default_nettype none
module tclt_mem import tclt_pkg::*; #(
	parameter int unsigned ENTRIES = ENTRIES_DEF,
	parameter int unsigned AW = $clog2(ENTRIES)
) (
	input  wire logic          clk,
	input  wire logic [AW-1:0] rd_addr,
	output entry_t             rd_data,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire entry_t        wr_data
);

	entry_t mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

// ===== rtl/tclt_ctrl.sv =====
// Sequencer: scans, updates and evicts slots through the slot memory.
`default_nettype none
module tclt_ctrl import tclt_pkg::*; #(
	parameter int unsigned ENTRIES = ENTRIES_DEF,
	parameter int unsigned AW = $clog2(ENTRIES),
	parameter int unsigned CW = $clog2(ENTRIES + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire req_t          req,
	output logic               busy,
	output logic               done,
	output rsp_t               rsp,
	output logic [AW-1:0]      rd_addr,
	input  wire entry_t        rd_data,
	output logic               wr_en,
	output logic [AW-1:0]      wr_addr,
	output entry_t             wr_data
);

	localparam logic [CW-1:0] CNT_ENTRIES = CW'(ENTRIES);
	localparam logic [CW-1:0] CNT_LAST    = CW'(ENTRIES - 1);
	localparam logic [AW-1:0] ADDR_LAST   = AW'(ENTRIES - 1);

	state_t        state_q, state_d;
	logic [CW-1:0] addr_q;
	logic [AW-1:0] addr_s1;
	logic          vld_s1;
	logic [AW-1:0] recent_q;
	logic          issue;

	req_t          req_q;
	logic [2:0]    status_q;
	logic [7:0]    slot_q;
	logic          load_q, build_q;
	logic [8:0]    cnt_q;
	logic [AW-1:0] avail_q, first_q, pick_q;
	logic          avail_vld_q, first_vld_q, pick_vld_q;
	logic [8:0]    tries_q;
	logic [31:0]   best_q;

	// Per-beat decode of the read data
	logic          want, is_lookup, hit, empty, stale, cand, last;
	logic          avail_any;
	logic [AW-1:0] alloc_addr;
	entry_t        touch_e, alloc_e;
	logic          touch_load, touch_build;

	assign want      = (req_q.action == ACT_NORMAL);
	assign is_lookup = (req_q.action inside {ACT_LOOKUP, ACT_NORMAL});
	assign hit       = (rd_data.tag == req_q.image_id);
	assign empty     = (rd_data.tag == 32'd0);
	assign stale     = (rd_data.last_use != 32'd0) && (rd_data.last_use < req_q.current_frame);
	assign cand      = (rd_data.last_use != 32'd0) && (rd_data.last_use < best_q);
	assign last      = vld_s1 && (addr_s1 == ADDR_LAST);
	assign avail_any = avail_vld_q || empty;
	assign alloc_addr = avail_vld_q ? avail_q : addr_s1;

	// Hit update of the entry just read
	always_comb begin
		touch_e          = rd_data;
		touch_load       = 1'b0;
		touch_build      = 1'b0;
		touch_e.last_use = req_q.current_frame;
		if (rd_data.version < req_q.image_version) begin
			touch_e.version   = req_q.image_version;
			touch_e.is_normal = 1'b0;
			touch_load        = 1'b1;
		end
		if (want && !touch_e.is_normal) begin
			touch_e.is_normal = 1'b1;
			touch_build       = 1'b1;
		end
	end

	always_comb begin
		alloc_e.tag       = req_q.image_id;
		alloc_e.last_use  = req_q.current_frame;
		alloc_e.version   = req_q.image_version;
		alloc_e.is_normal = want;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (addr_q == CNT_LAST) state_d = S_IDLE;
			S_IDLE: begin
				if (start) begin
					case (req.action)
						ACT_LOOKUP, ACT_NORMAL:
							state_d = (req.image_id == 32'd0) ? S_DONE : S_REC_RD;
						ACT_EV_OLD:   state_d = (req.evict_tries == 9'd0) ? S_DONE : S_OLD;
						ACT_EV_STALE: state_d = S_STALE;
						ACT_INVAL:    state_d = S_INVAL;
						default:      state_d = S_DONE;
					endcase
				end
			end
			S_REC_RD:  state_d = S_REC_CHK;
			S_REC_CHK: state_d = hit ? S_DONE : S_SCAN;
			S_SCAN: begin
				if (vld_s1 && hit) state_d = S_DONE;
				else if (last) state_d = avail_any ? S_DONE : S_STALE;
			end
			S_STALE: begin
				if (last) begin
					state_d = (is_lookup && (first_vld_q || stale)) ? S_ALLOC : S_DONE;
				end
			end
			S_ALLOC: state_d = S_DONE;
			S_INVAL: if (last) state_d = S_DONE;
			S_OLD: if (last) state_d = (pick_vld_q || cand) ? S_OLD_CLR : S_DONE;
			S_OLD_CLR: state_d = (tries_q == 9'd1) ? S_DONE : S_OLD;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_CLEAR;
		endcase
	end

	// Memory port and handshake outputs
	always_comb begin
		rd_addr = addr_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = addr_s1;
		wr_data = '0;
		done    = 1'b0;
		case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = addr_q[AW-1:0];
			end
			S_REC_RD: rd_addr = recent_q;
			S_REC_CHK: begin
				wr_en   = hit;
				wr_addr = recent_q;
				wr_data = touch_e;
			end
			S_SCAN: begin
				if (vld_s1 && hit) begin
					wr_en   = 1'b1;
					wr_data = touch_e;
				end else if (last && avail_any) begin
					wr_en   = 1'b1;
					wr_addr = alloc_addr;
					wr_data = alloc_e;
				end
			end
			S_STALE: wr_en = vld_s1 && stale;
			S_ALLOC: begin
				wr_en   = 1'b1;
				wr_addr = first_q;
				wr_data = alloc_e;
			end
			S_INVAL: wr_en = vld_s1;
			S_OLD_CLR: begin
				wr_en   = 1'b1;
				wr_addr = pick_q;
			end
			S_DONE: done = 1'b1;
			default: ;
		endcase
	end

	// Reads are issued in scan states only while the state holds
	assign issue = (state_q inside {S_SCAN, S_STALE, S_INVAL, S_OLD}) &&
		(state_d == state_q) && (addr_q < CNT_ENTRIES);
	assign busy = (state_q != S_IDLE);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			addr_q   <= '0;
			vld_s1   <= 1'b0;
			recent_q <= '0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue;
			if (state_d != state_q) addr_q <= '0;
			else if (issue || state_q == S_CLEAR) addr_q <= addr_q + 1'b1;
			if (state_q == S_SCAN && vld_s1 && hit) recent_q <= addr_s1;
			else if (state_q == S_SCAN && last && avail_any) recent_q <= alloc_addr;
			else if (state_q == S_ALLOC) recent_q <= first_q;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		addr_s1 <= addr_q[AW-1:0];
		case (state_q)
			S_IDLE: begin
				if (start) begin
					req_q       <= req;
					status_q    <= ((req.action inside {ACT_LOOKUP, ACT_NORMAL}) &&
						req.image_id == 32'd0) ? ST_NOIMAGE : ST_MAINT;
					slot_q      <= '0;
					load_q      <= 1'b0;
					build_q     <= 1'b0;
					cnt_q       <= '0;
					avail_vld_q <= 1'b0;
					first_vld_q <= 1'b0;
					pick_vld_q  <= 1'b0;
					tries_q     <= req.evict_tries;
					best_q      <= req.current_frame;
				end
			end
			S_REC_CHK: begin
				if (hit) begin
					status_q <= ST_HIT;
					slot_q   <= 8'(recent_q);
					load_q   <= touch_load;
					build_q  <= touch_build;
				end
			end
			S_SCAN: begin
				if (vld_s1 && hit) begin
					status_q <= ST_HIT;
					slot_q   <= 8'(addr_s1);
					load_q   <= touch_load;
					build_q  <= touch_build;
				end else if (vld_s1) begin
					if (empty && !avail_vld_q) begin
						avail_q     <= addr_s1;
						avail_vld_q <= 1'b1;
					end
					if (last && avail_any) begin
						status_q <= ST_MISS;
						slot_q   <= 8'(alloc_addr);
						load_q   <= 1'b1;
						build_q  <= want;
					end
				end
			end
			S_STALE: begin
				if (vld_s1 && stale) begin
					if (cnt_q != CNT_MAX) cnt_q <= cnt_q + 1'b1;
					if (!first_vld_q) begin
						first_q     <= addr_s1;
						first_vld_q <= 1'b1;
					end
				end
				if (last && is_lookup && !(first_vld_q || stale)) status_q <= ST_NOSPACE;
			end
			S_ALLOC: begin
				status_q <= ST_MISS;
				slot_q   <= 8'(first_q);
				load_q   <= 1'b1;
				build_q  <= want;
			end
			S_INVAL: begin
				if (vld_s1 && !empty && cnt_q != CNT_MAX) cnt_q <= cnt_q + 1'b1;
			end
			S_OLD: begin
				if (vld_s1 && cand) begin
					best_q     <= rd_data.last_use;
					pick_q     <= addr_s1;
					pick_vld_q <= 1'b1;
				end
			end
			S_OLD_CLR: begin
				if (cnt_q != CNT_MAX) cnt_q <= cnt_q + 1'b1;
				tries_q    <= tries_q - 1'b1;
				best_q     <= req_q.current_frame;
				pick_vld_q <= 1'b0;
			end
			default: ;
		endcase
	end

	assign rsp = '{status: status_q, slot: slot_q, load_needed: load_q,
		build_normal: build_q, evicted_count: cnt_q};

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for the texture cache LRU table: predicted lookups and evictions.
`timescale 1ns / 1ps
module tb;
	import tclt_pkg::*;

	localparam int NSLOT = 256;
	localparam longint CYCLE_LIMIT = 64'd10_000_000;

	logic clk;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic done;
	rsp_t rsp;

	texture_cache_lru_table dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .rsp(rsp)
	);

	// Predictor copy of the slot table
	logic [31:0] tag_q [NSLOT];
	logic [31:0] use_q [NSLOT];
	logic [31:0] ver_q [NSLOT];
	logic        nrm_q [NSLOT];
	int unsigned recent_q;

	req_t pending_reqs [$];
	rsp_t expected_rsps [$];
	int   mismatches;
	int   n_sent, n_got, n_hit, n_miss, n_full, n_evicting;
	longint cycles;
	bit   all_queued;
	bit   drain_hold;
	bit   taken;
	int   gap_left;

	function automatic int unsigned gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 4);
		return $urandom_range(20, 400);
	endfunction

	function automatic void wipe(int i);
		tag_q[i] = 0; use_q[i] = 0; ver_q[i] = 0; nrm_q[i] = 0;
	endfunction

	function automatic int unsigned purge_stale(logic [31:0] frame);
		int unsigned n;
		n = 0;
		for (int i = 0; i < NSLOT; i++)
			if (use_q[i] != 0 && use_q[i] < frame) begin
				wipe(i);
				n++;
			end
		return n;
	endfunction

	// Compute the response for one accepted request and update the table
	function automatic rsp_t predict_access(req_t r);
		rsp_t o;
		int found, avail, pick;
		int unsigned ev, tries;
		bit want_n;
		logic [31:0] best;
		o = '0;
		o.status = ST_MAINT;
		ev = 0;
		if (r.action == ACT_LOOKUP || r.action == ACT_NORMAL) begin
			want_n = (r.action == ACT_NORMAL);
			if (r.image_id == 0) begin
				o.status = ST_NOIMAGE;
			end else begin
				found = -1;
				avail = -1;
				if (tag_q[recent_q] == r.image_id) begin
					found = recent_q;
				end else begin
					for (int i = 0; i < NSLOT; i++) begin
						if (tag_q[i] == r.image_id) begin
							found = i;
							break;
						end
						if (avail < 0 && tag_q[i] == 0) avail = i;
					end
				end
				if (found >= 0) begin
					use_q[found] = r.current_frame;
					recent_q = found;
					if (ver_q[found] < r.image_version) begin
						ver_q[found] = r.image_version;
						nrm_q[found] = 0;
						o.load_needed = 1;
					end
					if (want_n && !nrm_q[found]) begin
						nrm_q[found] = 1;
						o.build_normal = 1;
					end
					o.status = ST_HIT;
					o.slot = 8'(found);
				end else begin
					if (avail < 0) begin
						ev = purge_stale(r.current_frame);
						if (ev != 0)
							for (int i = 0; i < NSLOT; i++)
								if (tag_q[i] == 0) begin
									avail = i;
									break;
								end
					end
					if (avail < 0) begin
						o.status = ST_NOSPACE;
					end else begin
						tag_q[avail] = r.image_id;
						use_q[avail] = r.current_frame;
						ver_q[avail] = r.image_version;
						nrm_q[avail] = want_n;
						recent_q = avail;
						o.status = ST_MISS;
						o.slot = 8'(avail);
						o.load_needed = 1;
						o.build_normal = want_n;
					end
				end
			end
		end else if (r.action == ACT_EV_OLD) begin
			tries = r.evict_tries;
			while (tries > 0) begin
				tries--;
				best = r.current_frame;
				pick = -1;
				for (int i = 0; i < NSLOT; i++)
					if (use_q[i] != 0 && use_q[i] < best) begin
						best = use_q[i];
						pick = i;
					end
				if (pick < 0) break;
				wipe(pick);
				ev++;
			end
		end else if (r.action == ACT_EV_STALE) begin
			ev = purge_stale(r.current_frame);
		end else if (r.action == ACT_INVAL) begin
			for (int i = 0; i < NSLOT; i++) begin
				if (tag_q[i] != 0) ev++;
				wipe(i);
			end
		end
		o.evicted_count = (ev > 511) ? CNT_MAX : ev[8:0];
		return o;
	endfunction

	function automatic req_t mk_req(logic [2:0] a, logic [31:0] id, logic [31:0] v,
			logic [31:0] f, logic [8:0] t);
		req_t r;
		r.action = a; r.image_id = id; r.image_version = v;
		r.current_frame = f; r.evict_tries = t;
		return r;
	endfunction

	// Clock
	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Beat taken at the rising edge
	always @(posedge clk) taken <= arst_n && start && !busy;

	// Driver: presents requests at the falling edge, random gaps between beats
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 0;
			req <= '0;
			gap_left <= 0;
		end else if (start && !taken) begin
			// holding the beat until the block takes it
		end else begin
			if (start) begin
				// previous beat was taken at the last rising edge
				expected_rsps.push_back(predict_access(req));
				n_sent++;
			end
			if (gap_left > 0) begin
				start <= 0;
				gap_left <= gap_left - 1;
			end else if (pending_reqs.size() > 0 && !(drain_hold &&
					(expected_rsps.size() > 0 || busy))) begin
				start <= 1;
				req <= pending_reqs.pop_front();
				gap_left <= gap_len();
			end else begin
				start <= 0;
			end
		end
	end

	// Monitor: checks each result beat against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			rsp_t e;
			n_got++;
			if (expected_rsps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat %p", rsp);
			end else begin
				e = expected_rsps.pop_front();
				if (rsp.status === ST_HIT) n_hit++;
				if (rsp.status === ST_MISS) n_miss++;
				if (rsp.status === ST_NOSPACE) n_full++;
				if (rsp.evicted_count !== 0) n_evicting++;
				if (rsp.status !== e.status || rsp.slot !== e.slot ||
						rsp.load_needed !== e.load_needed ||
						rsp.build_normal !== e.build_normal ||
						rsp.evicted_count !== e.evicted_count) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch beat %0d: expected %p, got %p", n_got, e, rsp);
				end
			end
		end
	end

	// Cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb: FAIL");
			$finish;
		end
	end

	// Random request: small pools of ids and frames so hits and fills happen
	function automatic req_t rand_req(int unsigned idpool, ref logic [31:0] frame);
		int r;
		logic [31:0] id, v;
		r = $urandom_range(0, 99);
		if ($urandom_range(0, 9) == 0) frame = frame + $urandom_range(1, 3);
		id = $urandom_range(1, idpool);
		if ($urandom_range(0, 30) == 0) id = $urandom;
		if ($urandom_range(0, 40) == 0) id = 0;
		v = $urandom_range(0, 6);
		if ($urandom_range(0, 30) == 0) v = $urandom;
		if (r < 55) return mk_req(ACT_LOOKUP, id, v, frame, $urandom);
		if (r < 85) return mk_req(ACT_NORMAL, id, v, frame, $urandom);
		if (r < 92) return mk_req(ACT_EV_OLD, $urandom, $urandom, frame,
			($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 8));
		if (r < 96) return mk_req(ACT_EV_STALE, $urandom, $urandom,
			frame - $urandom_range(0, 2), $urandom);
		if (r < 98) return mk_req(ACT_INVAL, $urandom, $urandom, frame, $urandom);
		return mk_req($urandom_range(5, 7), $urandom, $urandom, $urandom, $urandom);
	endfunction

	// Stimulus and end of run
	initial begin
		logic [31:0] frame;
		arst_n = 0;
		start = 0;
		req = '0;
		mismatches = 0; n_sent = 0; n_got = 0; n_hit = 0; n_miss = 0;
		n_full = 0; n_evicting = 0; cycles = 0;
		all_queued = 0; drain_hold = 0; gap_left = 0;
		for (int i = 0; i < NSLOT; i++) wipe(i);
		recent_q = 0;

		// directed: no image, misses, hits, version bump, normal build
		pending_reqs.push_back(mk_req(ACT_LOOKUP, 0, 0, 1, 0));
		pending_reqs.push_back(mk_req(ACT_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 9'h1FF));
		pending_reqs.push_back(mk_req(ACT_LOOKUP, 5, 3, 1, 0));
		pending_reqs.push_back(mk_req(ACT_NORMAL, 5, 3, 1, 0));
		pending_reqs.push_back(mk_req(ACT_NORMAL, 5, 3, 2, 0));
		pending_reqs.push_back(mk_req(ACT_LOOKUP, 5, 4, 2, 0));
		pending_reqs.push_back(mk_req(ACT_NORMAL, 7, 0, 2, 0));
		pending_reqs.push_back(mk_req(ACT_LOOKUP, 32'hFFFF_FFFF, 1, 3, 0));
		pending_reqs.push_back(mk_req(ACT_EV_OLD, 0, 0, 3, 1));
		pending_reqs.push_back(mk_req(ACT_EV_OLD, 0, 0, 32'hFFFF_FFFF, 9'h1FF));
		pending_reqs.push_back(mk_req(ACT_LOOKUP, 9, 0, 4, 0));
		pending_reqs.push_back(mk_req(ACT_EV_STALE, 0, 0, 5, 0));
		pending_reqs.push_back(mk_req(5, 1, 1, 1, 1));
		pending_reqs.push_back(mk_req(7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'h1FF));
		// fill the table at frame 10, then overflow at frame 10 (no space)
		for (int i = 0; i < NSLOT; i++)
			pending_reqs.push_back(mk_req(ACT_LOOKUP, 1000 + i, i, 10, 0));
		pending_reqs.push_back(mk_req(ACT_NORMAL, 5000, 0, 10, 0));
		// overflow at a later frame evicts all stale entries
		pending_reqs.push_back(mk_req(ACT_NORMAL, 5001, 0, 11, 0));
		pending_reqs.push_back(mk_req(ACT_INVAL, 0, 0, 0, 0));

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1;

		// random part, with a drain point in the middle
		frame = 20;
		for (int k = 0; k < 880; k++) begin
			pending_reqs.push_back(rand_req((k < 450) ? 40 : 300, frame));
			if (k == 400) begin
				wait (pending_reqs.size() < 5);
				drain_hold = 1;
				wait (pending_reqs.size() == 0 && expected_rsps.size() == 0 && !start);
				drain_hold = 0;
			end
		end
		wait (pending_reqs.size() == 0);
		@(negedge clk);
		wait (!start && expected_rsps.size() == 0);
		repeat (200) @(posedge clk);
		$display("covered %0d requests: %0d hits, %0d allocations, %0d full-table refusals,",
			n_sent, n_hit, n_miss, n_full);
		$display("  %0d results that evicted entries", n_evicting);
		if (mismatches == 0 && expected_rsps.size() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("%0d mismatches, %0d predictions left", mismatches, expected_rsps.size());
			$display("tb: FAIL");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/tclt_pkg.sv
rtl/tclt_mem.sv
rtl/tclt_ctrl.sv
rtl/texture_cache_lru_table.sv
sim/tb.sv
